@@ sv/blrf_pkg.sv @@
// Shared types and constants for the line rasterizer and its frame store.
`default_nettype none
package blrf_pkg;

  // Operation codes carried by func and echoed on op_done
  typedef enum logic [1:0] {
    FN_LINE = 2'd0,
    FN_FILL = 2'd1,
    FN_READ = 2'd2,
    FN_NOP  = 2'd3
  } func_t;

  localparam logic [7:0] PIX_MSB   = 8'h80;
  localparam logic [7:0] FILL_BYTE = 8'hFF;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic sweep;
    logic step;
    logic rd;
    logic result;
  } blrf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sweep_last;
    logic at_end;
    logic wb_pend;
  } blrf_sts_t;

endpackage
`default_nettype wire

@@ sv/blrf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module blrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4736,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read during write to the same address returns the old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ sv/blrf_dp.sv @@
// Datapath: Bresenham stepper, pixel address mapping, frame store and result register.
`default_nettype none
module blrf_dp #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 296
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire blrf_pkg::blrf_cmd_t cmd,
  output blrf_pkg::blrf_sts_t      sts,
  input  wire logic [1:0]          in_func,
  input  wire logic signed [10:0]  in_x_start,
  input  wire logic signed [10:0]  in_y_start,
  input  wire logic signed [10:0]  in_x_end,
  input  wire logic signed [10:0]  in_y_end,
  input  wire logic                in_ink,
  input  wire logic [12:0]         in_read_address,
  output logic [7:0]               out_read_data,
  output logic [1:0]               out_op_done
);

  localparam int STRIDE      = (PANEL_WIDTH + 7) / 8;
  localparam int STORE_BYTES = STRIDE * PANEL_HEIGHT;
  localparam int AW          = $clog2(STORE_BYTES);

  // Captured item
  logic [1:0]          op_r;
  logic                ink_r;
  logic                rd_ok_r;
  logic [AW-1:0]       rd_addr_r;

  // Bresenham state
  logic signed [10:0]  x_r, x_nxt, y_r, y_nxt, x1_r, y1_r;
  logic signed [13:0]  dx_r, dy_r, err_r, err_nxt;
  logic                sx_r, sy_r;

  // Sweep counter for fill and the reset clearing pass
  logic [AW-1:0]       cnt_r, cnt_nxt;

  // Write-back stage and last-write bypass
  logic                pend_v_r;
  logic [AW-1:0]       pend_addr_r;
  logic [7:0]          pend_mask_r;
  logic                last_v_r;
  logic [AW-1:0]       last_addr_r;
  logic [7:0]          last_data_r;

  logic [7:0]          out_read_data_r;
  logic [1:0]          out_op_done_r;

  logic signed [13:0]  xd, yd, dx_ld, dy_ld;
  logic signed [14:0]  e2;
  logic                mv_x, mv_y;
  logic signed [12:0]  row_s;
  logic                on_panel;
  logic [AW-1:0]       pix_idx;
  logic [7:0]          pix_mask;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [7:0]          ram_wdata, ram_rdata;
  logic [7:0]          wb_base, wb_data;

  // Line setup
  always_comb begin
    xd    = 14'(in_x_end) - 14'(in_x_start);
    yd    = 14'(in_y_end) - 14'(in_y_start);
    dx_ld = (xd < 0) ? -xd : xd;
    dy_ld = (yd < 0) ? yd : -yd;
  end

  // One Bresenham step
  always_comb begin
    e2   = {err_r, 1'b0};
    mv_x = (e2 >= 15'(dy_r));
    mv_y = (e2 <= 15'(dx_r));
    err_nxt = err_r + (mv_x ? dy_r : 14'sd0) + (mv_y ? dx_r : 14'sd0);
    x_nxt   = x_r + (mv_x ? (sx_r ? 11'sd1 : -11'sd1) : 11'sd0);
    y_nxt   = y_r + (mv_y ? (sy_r ? 11'sd1 : -11'sd1) : 11'sd0);
  end

  // Rotate landscape point onto the portrait panel: column is y, row is H-1-x
  always_comb begin
    row_s    = 13'(PANEL_HEIGHT - 1) - 13'(x_r);
    on_panel = (y_r >= 0) && (int'(y_r) < PANEL_WIDTH) &&
               (row_s >= 0) && (int'(row_s) < PANEL_HEIGHT);
    pix_idx  = AW'(y_r[9:3]) + AW'(row_s[9:0]) * AW'(STRIDE);
    pix_mask = blrf_pkg::PIX_MSB >> y_r[2:0];
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      cnt_nxt = '0;
    end else if (cmd.sweep) begin
      cnt_nxt = cnt_r + AW'(1);
    end
  end

  // Read-modify-write: bypass the byte written in the cycle the read was issued
  always_comb begin
    wb_base   = (last_v_r && (last_addr_r == pend_addr_r)) ? last_data_r : ram_rdata;
    wb_data   = ink_r ? (wb_base | pend_mask_r) : (wb_base & ~pend_mask_r);
    ram_we    = cmd.sweep || pend_v_r;
    ram_waddr = cmd.sweep ? cnt_r : pend_addr_r;
    ram_wdata = cmd.sweep ? blrf_pkg::FILL_BYTE : wb_data;
    ram_re    = (cmd.step && on_panel) || cmd.rd;
    ram_raddr = cmd.rd ? rd_addr_r : pix_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      pend_v_r <= 1'b0;
      last_v_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      pend_v_r <= cmd.step && on_panel;
      last_v_r <= ram_we;
    end
  end

  always_ff @(posedge clk) begin
    last_addr_r <= ram_waddr;
    last_data_r <= ram_wdata;
    if (cmd.step) begin
      pend_addr_r <= pix_idx;
      pend_mask_r <= pix_mask;
    end
    if (cmd.load) begin
      op_r      <= in_func;
      ink_r     <= in_ink;
      rd_ok_r   <= (int'(in_read_address) < STORE_BYTES);
      rd_addr_r <= AW'(in_read_address);
      x_r       <= in_x_start;
      y_r       <= in_y_start;
      x1_r      <= in_x_end;
      y1_r      <= in_y_end;
      dx_r      <= dx_ld;
      dy_r      <= dy_ld;
      sx_r      <= (xd > 0);
      sy_r      <= (yd > 0);
      err_r     <= dx_ld + dy_ld;
    end else if (cmd.step) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      err_r <= err_nxt;
    end
    if (cmd.result) begin
      out_read_data_r <= ((op_r == blrf_pkg::FN_READ) && rd_ok_r) ? ram_rdata : 8'h00;
      out_op_done_r   <= op_r;
    end
  end

  blrf_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign sts.sweep_last = (cnt_r == AW'(STORE_BYTES - 1));
  assign sts.at_end     = (x_r == x1_r) && (y_r == y1_r);
  assign sts.wb_pend    = pend_v_r;
  assign out_read_data  = out_read_data_r;
  assign out_op_done    = out_op_done_r;

endmodule
`default_nettype wire

@@ sv/blrf_ctrl.sv @@
// Controller: sequences clearing pass, line walk, fill, read and result hand-off.
`default_nettype none
module blrf_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          in_func,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output blrf_pkg::blrf_cmd_t      cmd,
  input  wire blrf_pkg::blrf_sts_t sts
);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_LINE  = 7'b0000100,
    S_DRAIN = 7'b0001000,
    S_FILL  = 7'b0010000,
    S_READ  = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_func)
            blrf_pkg::FN_LINE: state_nxt = S_LINE;
            blrf_pkg::FN_FILL: state_nxt = S_FILL;
            blrf_pkg::FN_READ: state_nxt = S_READ;
            default:           state_nxt = S_DONE;
          endcase
        end
      end
      S_LINE: begin
        cmd.step = 1'b1;
        if (sts.at_end) state_nxt = S_DRAIN;
      end
      // let the last pixel's write-back land
      S_DRAIN: state_nxt = S_DONE;
      S_FILL: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) state_nxt = S_DONE;
      end
      S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.result = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_no_reclear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_CLEAR) |=> (state_r != S_CLEAR))
    else $error("clearing pass re-entered after reset");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !sts.wb_pend)
    else $error("pixel write-back pending while idle");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside of completion");

  a_fill_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FILL) && sts.sweep_last |=> (state_r == S_DONE))
    else $error("fill sweep did not finish at last byte");

endmodule
`default_nettype wire

@@ sv/bresenham_line_to_rotated_framebuffer_unit.sv @@
// Line: one Bresenham step per cycle over N = max(|dx|,|dy|)+1 points, with the frame
// store read-modify-write overlapped; the last write-back drains before the result.
// Fill writes one byte per cycle on the store write port; read issues a single store read.
// Throughput: one item at a time; the next is accepted once the current result is loaded.
// Reset: synchronous active-low; afterwards a clearing pass writes 0xFF to all
// STORE_BYTES bytes (4736 bytes at default size) before the first item is accepted.
`default_nettype none
module bresenham_line_to_rotated_framebuffer_unit #(
  parameter int PANEL_WIDTH  = 128,
  parameter int PANEL_HEIGHT = 296
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_func,
  input  wire logic signed [10:0] in_x_start,
  input  wire logic signed [10:0] in_y_start,
  input  wire logic signed [10:0] in_x_end,
  input  wire logic signed [10:0] in_y_end,
  input  wire logic               in_ink,
  input  wire logic [12:0]        in_read_address,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_read_data,
  output logic [1:0]              out_op_done
);

  blrf_pkg::blrf_cmd_t cmd;
  blrf_pkg::blrf_sts_t sts;

  blrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  blrf_dp #(
    .PANEL_WIDTH  (PANEL_WIDTH),
    .PANEL_HEIGHT (PANEL_HEIGHT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_func),
    .in_x_start      (in_x_start),
    .in_y_start      (in_y_start),
    .in_x_end        (in_x_end),
    .in_y_end        (in_y_end),
    .in_ink          (in_ink),
    .in_read_address (in_read_address),
    .out_read_data   (out_read_data),
    .out_op_done     (out_op_done)
  );

endmodule
`default_nettype wire
